### hw/rtl/rgbhsl_pkg.sv
// Package for the RGB to HSL converter: widths, word types and constants.
// No dependencies.
package rgbhsl_pkg;

    localparam int CHAN_W = 8;
    localparam int OUT_W  = 16;
    // Quotient bits produced by the divider chain.
    localparam int QUO_W  = 16;
    // Widest dividend: 65535 * 255 fits in 24 bits, 6 * 255 * 65536 in 27.
    localparam int NUM_W  = 27;
    localparam int DEN_W  = 11;

    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // One division in flight: partial remainder, divisor and quotient.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_word_t;

endpackage

### hw/rtl/rgb_to_hsl_converter_unit.sv
// Top level of the RGB to HSL converter: front stage and two chains of
// divider cells. Depends on rgbhsl_pkg, rgbhsl_front and rgbhsl_div_cell.
//
// Usage: drive red, green and blue with start high; a word is taken at
// every clock edge where start is high (busy is always low, the pipeline
// accepts one word per cycle). Each word gives one result on hue,
// saturation and lightness, marked by done for one cycle. The front
// register loads on the accepting edge; the word then passes the 16
// division cells of each chain and the output register, and done rises
// with the output register. Throughput is one word per cycle.
// The latency is set by the two rows of 16 division cells, one
// quotient bit per cell. Results follow input order. The receiver cannot
// stall, so results are never held. Reset clears the valid pipe only; no
// done is raised until words arrive after reset.
module rgb_to_hsl_converter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        done,
    output logic [15:0] hue,
    output logic [15:0] saturation,
    output logic [15:0] lightness
);
    import rgbhsl_pkg::*;

    localparam int LAT = QUO_W + 1;

    div_word_t        hchain [QUO_W+1];
    div_word_t        schain [QUO_W+1];
    logic [OUT_W-1:0] light_pipe_reg [QUO_W+1];
    logic             grey_pipe_reg  [QUO_W+1];
    logic [LAT:0]     vld_reg, vld_next;
    logic [OUT_W-1:0] light0;
    logic             grey0;
    logic [OUT_W-1:0] hue_reg, sat_reg, light_reg;

    rgbhsl_front u_front (
        .clk(clk), .red(red), .green(green), .blue(blue),
        .hue_word(hchain[0]), .sat_word(schain[0]),
        .light(light0), .grey(grey0)
    );

    // Division cells, most significant quotient bit first.
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        rgbhsl_div_cell #(.BIT_POS(QUO_W-1-i)) u_hcell (
            .clk(clk), .din(hchain[i]), .dout(hchain[i+1]));
        rgbhsl_div_cell #(.BIT_POS(QUO_W-1-i)) u_scell (
            .clk(clk), .din(schain[i]), .dout(schain[i+1]));
    end

    // Lightness and grey flag ride alongside the division cells.
    always_ff @(posedge clk)
    begin
        light_pipe_reg[0] <= light0;
        grey_pipe_reg[0]  <= grey0;
        for (int k = 1; k <= QUO_W; k++)
        begin
            light_pipe_reg[k] <= light_pipe_reg[k-1];
            grey_pipe_reg[k]  <= grey_pipe_reg[k-1];
        end
        hue_reg   <= grey_pipe_reg[QUO_W-1] ? '0 : hchain[QUO_W].quo;
        sat_reg   <= grey_pipe_reg[QUO_W-1] ? '0 : schain[QUO_W].quo;
        light_reg <= light_pipe_reg[QUO_W-1];
    end

    // Valid bits track words through the pipe.
    assign vld_next = {vld_reg[LAT-1:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign busy       = 1'b0;
    assign done       = vld_reg[LAT];
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign lightness  = light_reg;

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT + 1))
        else $error("done without a start");
    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start ##(LAT + 1) 1'b1 |-> done || !rst_n)
        else $error("start lost");
    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && grey_pipe_reg[QUO_W] |-> hue == '0 && saturation == '0)
        else $error("grey pixel with nonzero hue or saturation");
endmodule

### hw/rtl/rgbhsl_div_cell.sv
// One restoring division cell: resolves one quotient bit per cycle.
// Depends on rgbhsl_pkg.
module rgbhsl_div_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                  clk,
    input  rgbhsl_pkg::div_word_t din,
    output rgbhsl_pkg::div_word_t dout
);
    import rgbhsl_pkg::*;

    localparam int SHW = NUM_W + BIT_POS;

    logic [SHW-1:0]   trial;
    logic             fits;
    div_word_t        dout_next;
    div_word_t        dout_reg;

    // Compare remainder against the divisor shifted to this bit position.
    always_comb
    begin
        trial     = SHW'(din.den) << BIT_POS;
        fits      = SHW'(din.rem) >= trial;
        dout_next = din;
        if (fits)
        begin
            dout_next.rem          = NUM_W'(SHW'(din.rem) - trial);
            dout_next.quo[BIT_POS] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule

### hw/rtl/rgbhsl_front.sv
// Front stage: max, min, sector, dividends and divisors for hue and saturation, lightness and grey flag.
// Depends on rgbhsl_pkg.
module rgbhsl_front (
    input  logic                         clk,
    input  logic [rgbhsl_pkg::CHAN_W-1:0] red,
    input  logic [rgbhsl_pkg::CHAN_W-1:0] green,
    input  logic [rgbhsl_pkg::CHAN_W-1:0] blue,
    output rgbhsl_pkg::div_word_t        hue_word,
    output rgbhsl_pkg::div_word_t        sat_word,
    output logic [rgbhsl_pkg::OUT_W-1:0] light,
    output logic                         grey
);
    import rgbhsl_pkg::*;

    logic [CHAN_W-1:0] mx, mn, d;
    logic [CHAN_W:0]   sum;
    sector_t           sect;
    logic [DEN_W-1:0]  h6, sden;
    logic [OUT_W-1:0]  light_next;
    div_word_t         hue_next, sat_next, hue_reg, sat_reg;
    logic [OUT_W-1:0]  light_reg;
    logic              grey_reg;

    // Largest channel picks the sector; red wins ties, then green.
    always_comb
    begin
        mx   = red;
        sect = SECT_RED;
        if (green > mx)
        begin
            mx   = green;
            sect = SECT_GREEN;
        end
        if (blue > mx)
        begin
            mx   = blue;
            sect = SECT_BLUE;
        end
        mn = red;
        if (green < mn) mn = green;
        if (blue < mn) mn = blue;
        d   = mx - mn;
        sum = {1'b0, mx} + {1'b0, mn};
        unique case (sect)
            SECT_RED:
                h6 = (green >= blue) ? DEN_W'(green - blue)
                                     : DEN_W'(11'd6 * d - DEN_W'(blue - green));
            SECT_GREEN: h6 = DEN_W'(11'd2 * d) + DEN_W'(blue) - DEN_W'(red);
            SECT_BLUE:  h6 = DEN_W'(11'd4 * d) + DEN_W'(red) - DEN_W'(green);
            default:    h6 = '0;
        endcase
        sden = (sum > 9'd255) ? DEN_W'(10'd510 - 10'(sum)) : DEN_W'(sum);
        // Since 65535 = 128 * 510 + 255, sum * 65535 / 510 is 128 * sum plus
        // half of sum, both truncated exactly.
        light_next = OUT_W'({sum, 7'd0}) + OUT_W'(sum[CHAN_W:1]);
        hue_next.rem = NUM_W'(h6) << 16;
        hue_next.den = DEN_W'(11'd6 * d);
        hue_next.quo = '0;
        sat_next.rem = NUM_W'(d) * NUM_W'(65535);
        sat_next.den = sden;
        sat_next.quo = '0;
        // Keep divisors nonzero for grey pixels; the result is dropped.
        if (d == '0)
        begin
            hue_next.den = DEN_W'(1);
            sat_next.den = DEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        hue_reg   <= hue_next;
        sat_reg   <= sat_next;
        light_reg <= light_next;
        grey_reg  <= (d == '0);
    end

    assign hue_word = hue_reg;
    assign sat_word = sat_reg;
    assign light    = light_reg;
    assign grey     = grey_reg;
endmodule

### sim/rgb_to_hsl_converter_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the RGB to HSL converter: drives pixel words, predicts
// hue, saturation and lightness, and checks each result. Needs only the RTL.
module rgb_to_hsl_converter_unit_tb;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [15:0] h;
        logic [15:0] s;
        logic [15:0] l;
    } hsl_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        done;
    logic [15:0] hue;
    logic [15:0] saturation;
    logic [15:0] lightness;

    pixel_t pixel_q[$];
    hsl_t   hsl_q[$];
    int     idle_pct;
    bit     hold_drain;
    int     err_cnt;

    rgb_to_hsl_converter_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .done       (done),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness)
    );

    // Clock with an 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Exact integer conversion of one pixel.
    function automatic hsl_t convert_pixel(pixel_t p);
        int unsigned mx, mn, d, sum, den, h6;
        hsl_t res;
        mx = p.r;
        mn = p.r;
        if (p.g > mx) mx = p.g;
        if (p.b > mx) mx = p.b;
        if (p.g < mn) mn = p.g;
        if (p.b < mn) mn = p.b;
        d = mx - mn;
        sum = mx + mn;
        res.l = 16'((sum * 65535) / 510);
        res.h = '0;
        res.s = '0;
        if (d != 0)
        begin
            den = (sum > 255) ? (510 - sum) : sum;
            res.s = 16'((d * 65535) / den);
            if (mx == p.r)
                h6 = (p.g >= p.b) ? (p.g - p.b) : (6 * d - (p.b - p.g));
            else if (mx == p.g)
                h6 = 2 * d + p.b - p.r;
            else
                h6 = 4 * d + p.r - p.g;
            res.h = 16'((h6 * 65536) / (6 * d));
        end
        return res;
    endfunction

    // Driver: presents the next pending word unless idling or draining.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            red   <= '0;
            green <= '0;
            blue  <= '0;
        end
        else
        begin
            if (start && !busy)
                hsl_q.push_back(convert_pixel({red, green, blue}));
            if (!(start && busy))
            begin
                if (pixel_q.size() > 0 && !hold_drain &&
                    $urandom_range(99, 0) >= idle_pct)
                begin
                    pixel_t p;
                    p = pixel_q.pop_front();
                    start <= 1'b1;
                    red   <= p.r;
                    green <= p.g;
                    blue  <= p.b;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: each strobed result is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (hsl_q.size() == 0)
            begin
                $error("result word with nothing expected");
                err_cnt++;
            end
            else
            begin
                hsl_t e;
                e = hsl_q.pop_front();
                if (hue !== e.h)
                begin
                    $error("hue: expected %0d, actual %0d", e.h, hue);
                    err_cnt++;
                end
                if (saturation !== e.s)
                begin
                    $error("saturation: expected %0d, actual %0d", e.s, saturation);
                    err_cnt++;
                end
                if (lightness !== e.l)
                begin
                    $error("lightness: expected %0d, actual %0d", e.l, lightness);
                    err_cnt++;
                end
            end
        end
    end

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int unsigned kind;
        kind = $urandom_range(9, 0);
        p = pixel_t'($urandom);
        // Mix in greys and ties so the special cases recur.
        if (kind == 0)
        begin
            p.g = p.r;
            p.b = p.r;
        end
        else if (kind == 1)
            p.g = p.r;
        else if (kind == 2)
            p.b = p.g;
        else if (kind == 3)
            p.b = p.r;
        return p;
    endfunction

    task automatic wait_empty();
        while (pixel_q.size() > 0 || start || hsl_q.size() > 0)
            @(posedge clk);
    endtask

    // Stimulus in three idling phases, with a full drain pause after the first.
    initial
    begin
        err_cnt = 0;
        idle_pct = 27;
        hold_drain = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words: extremes, greys, every sector, every tie.
        pixel_q.push_back('{8'd0, 8'd0, 8'd0});
        pixel_q.push_back('{8'd255, 8'd255, 8'd255});
        pixel_q.push_back('{8'd128, 8'd128, 8'd128});
        pixel_q.push_back('{8'd255, 8'd0, 8'd0});
        pixel_q.push_back('{8'd0, 8'd255, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd255});
        pixel_q.push_back('{8'd255, 8'd255, 8'd0});
        pixel_q.push_back('{8'd0, 8'd255, 8'd255});
        pixel_q.push_back('{8'd255, 8'd0, 8'd255});
        pixel_q.push_back('{8'd255, 8'd0, 8'd1});
        pixel_q.push_back('{8'd255, 8'd1, 8'd0});
        pixel_q.push_back('{8'd1, 8'd0, 8'd0});
        pixel_q.push_back('{8'd254, 8'd255, 8'd255});
        pixel_q.push_back('{8'd128, 8'd127, 8'd127});
        pixel_q.push_back('{8'd127, 8'd128, 8'd128});
        pixel_q.push_back('{8'd10, 8'd200, 8'd30});
        pixel_q.push_back('{8'd90, 8'd20, 8'd240});
        pixel_q.push_back('{8'd170, 8'd85, 8'd85});
        pixel_q.push_back('{8'd0, 8'd1, 8'd0});
        pixel_q.push_back('{8'd0, 8'd0, 8'd1});
        for (int i = 0; i < 480; i++)
            pixel_q.push_back(rand_pixel());
        while (pixel_q.size() > 0)
            @(posedge clk);

        // Hold off until every expected result has come back.
        hold_drain = 1'b1;
        wait_empty();
        hold_drain = 1'b0;

        idle_pct = 84;
        for (int i = 0; i < 500; i++)
            pixel_q.push_back(rand_pixel());
        while (pixel_q.size() > 0)
            @(posedge clk);

        idle_pct = 0;
        for (int i = 0; i < 500; i++)
            pixel_q.push_back(rand_pixel());
        wait_empty();
        repeat (30) @(posedge clk);

        if (err_cnt == 0)
            $display("rgb_to_hsl_converter_unit_tb: PASS");
        else
            $display("rgb_to_hsl_converter_unit_tb: FAIL");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #2000000;
        $display("rgb_to_hsl_converter_unit_tb: FAIL");
        $finish;
    end

endmodule
